>>> rtl/ctwb_pkg.sv
// Shared types, constants and codes of the transform composer and bounds unit.
package ctwb_pkg;

    // Default number format: signed Q32.32 in a 64-bit word
    localparam int VALUE_WIDTH = 64;
    localparam int FRAC_BITS   = 32;

    // Fixed widths of the datapath
    localparam int DATA_W    = 64;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 128;
    localparam int MUL_CELLS = 4;
    localparam int ADDR_W    = 7;

    // Command codes
    localparam logic [1:0] CMD_LOAD_FIXED  = 2'd0;
    localparam logic [1:0] CMD_LOAD_PLACE  = 2'd1;
    localparam logic [1:0] CMD_LOAD_BOUNDS = 2'd2;
    localparam logic [1:0] CMD_COMPUTE     = 2'd3;

    // Selector and axis codes that name nothing
    localparam logic [1:0] SEL_NONE  = 2'd3;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Result kinds
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_BOUNDS = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         matrix_sel;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [63:0] value_a;
        logic signed [63:0] value_b;
    } in_word_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [63:0] first_value;
        logic signed [63:0] second_value;
        logic               last;
    } out_word_t;

    // Bookkeeping that travels with each product
    typedef struct packed {
        logic              valid;
        logic              bounds;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] dest;
        logic [1:0]        ax;
        logic [2:0]        corner;
    } tag_t;

    // What one multiplier cell hands to the next
    typedef struct packed {
        tag_t              tag;
        logic              neg;
        logic [DATA_W-1:0] a_mag;
        logic [DATA_W-1:0] b_mag;
        logic [PROD_W-1:0] acc;
    } mul_lane_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAT,
        ST_BND,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMIT_WAIT
    } state_t;

endpackage

>>> rtl/compose_transform_and_world_bounds.sv
// Top level: operand store, compute sequencer, accumulator and result register.
//
// Load words (fixed matrix entry, placement entry, axis bounds) are taken one per
// cycle while the block is idle. A compute word forms F0*F1*F2*P through a single
// chain of four multiplier cells that takes one product per cycle: 192 products
// for the three matrix products, 96 for the eight box corners of three axes,
// then a drain of the multiplier. The 16 composed entries (column-major) and
// three axis bounds follow, one at a time, each held until the sink is ready.
// Values are signed fixed point; products round half up and all sums saturate.
// No clearing pass runs after reset.
module compose_transform_and_world_bounds #(
    parameter int VALUE_WIDTH = ctwb_pkg::VALUE_WIDTH,
    parameter int FRAC_BITS   = ctwb_pkg::FRAC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ctwb_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ctwb_pkg::out_word_t m_data
);

    localparam int AW        = ctwb_pkg::ADDR_W;
    localparam int MEM_DEPTH = 112;
    localparam logic [2:0] REG_F0 = 3'd0;
    localparam logic [2:0] REG_F1 = 3'd1;
    localparam logic [2:0] REG_F2 = 3'd2;
    localparam logic [2:0] REG_P  = 3'd3;
    localparam logic [2:0] REG_T1 = 3'd4;
    localparam logic [2:0] REG_T2 = 3'd5;
    localparam logic [2:0] REG_C  = 3'd6;
    localparam logic [1:0] PH_LAST      = 2'd2;
    localparam logic [6:0] BND_LAST     = 7'd95;
    localparam logic [3:0] DRAIN_LAST   = 4'd9;
    localparam logic [4:0] EMIT_LAST    = 5'd18;
    localparam logic [2:0] CORNER_LAST  = 3'd7;
    localparam logic [1:0] AXIS_LAST    = 2'd2;
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [64:0] VMAX_X = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] VMIN_X = -VMAX_X - 65'sd1;
    localparam logic signed [63:0] VMAX = VMAX_X[63:0];
    localparam logic signed [63:0] VMIN = VMIN_X[63:0];

    ctwb_pkg::state_t    state_reg, state_next;
    logic [1:0]          ph_reg, ph_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [3:0]          drain_reg, drain_next;
    logic [4:0]          emit_reg, emit_next;
    logic [2:0]          base_a, base_b, base_d;
    logic [AW-1:0]       addr_a, addr_b;
    ctwb_pkg::tag_t      issue_tag, tag1_reg;
    logic signed [63:0]  bnd_op_next, bnd_reg;
    logic signed [63:0]  rd_a_reg, rd_b_reg, mul_b;
    ctwb_pkg::tag_t      res_tag;
    logic signed [63:0]  res_value;
    logic signed [63:0]  acc_reg, acc_sum;
    logic signed [63:0]  lo_run_reg, hi_run_reg, lo_new, hi_new;
    logic signed [63:0]  lo_res_reg [3];
    logic signed [63:0]  hi_res_reg [3];
    logic signed [63:0]  lower_reg [3];
    logic signed [63:0]  upper_reg [3];
    logic [63:0]         mem [MEM_DEPTH];
    logic                mem_we, acc_we, load_fire;
    logic [AW-1:0]       mem_waddr;
    logic signed [63:0]  mem_wdata;
    ctwb_pkg::out_word_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // Saturate a loaded value to the value range
    function automatic logic signed [63:0] sat_in(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = v >>> (VALUE_WIDTH - 1);
        if ((hi == '0) || (hi == '1)) begin
            return v;
        end
        return v[63] ? VMIN : VMAX;
    endfunction

    // Saturating add of two in-range values
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > VMAX_X) begin
            return VMAX;
        end
        if (s < VMIN_X) begin
            return VMIN;
        end
        return s[63:0];
    endfunction

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctwb_pkg::ST_IDLE: begin
                if (s_valid && (s_data.cmd == ctwb_pkg::CMD_COMPUTE)) begin
                    state_next = ctwb_pkg::ST_MAT;
                end
            end
            ctwb_pkg::ST_MAT: begin
                if ((cnt_reg[5:0] == 6'd63) && (ph_reg == PH_LAST)) begin
                    state_next = ctwb_pkg::ST_BND;
                end
            end
            ctwb_pkg::ST_BND: begin
                if (cnt_reg == BND_LAST) begin
                    state_next = ctwb_pkg::ST_DRAIN;
                end
            end
            ctwb_pkg::ST_DRAIN: begin
                if (drain_reg == DRAIN_LAST) begin
                    state_next = ctwb_pkg::ST_EMIT_RD;
                end
            end
            ctwb_pkg::ST_EMIT_RD:  state_next = ctwb_pkg::ST_EMIT_OUT;
            ctwb_pkg::ST_EMIT_OUT: state_next = ctwb_pkg::ST_EMIT_WAIT;
            ctwb_pkg::ST_EMIT_WAIT: begin
                if (m_ready) begin
                    state_next = (emit_reg == EMIT_LAST) ? ctwb_pkg::ST_IDLE
                                                         : ctwb_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = ctwb_pkg::ST_IDLE;
        endcase
    end

    // Operand regions of each matrix product
    always_comb begin
        unique case (ph_reg)
            2'd0:    begin base_a = REG_F0; base_b = REG_F1; base_d = REG_T1; end
            2'd1:    begin base_a = REG_T1; base_b = REG_F2; base_d = REG_T2; end
            default: begin base_a = REG_T2; base_b = REG_P;  base_d = REG_C;  end
        endcase
    end

    // Corner coordinate, or unity for the translation term
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    bnd_op_next = cnt_reg[2] ? upper_reg[0] : lower_reg[0];
            2'd1:    bnd_op_next = cnt_reg[3] ? upper_reg[1] : lower_reg[1];
            2'd2:    bnd_op_next = cnt_reg[4] ? upper_reg[2] : lower_reg[2];
            default: bnd_op_next = ONE;
        endcase
    end

    // State outputs: issue, counters and result register
    always_comb begin
        s_ready      = 1'b0;
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        drain_next   = drain_reg;
        emit_next    = emit_reg;
        addr_a       = '0;
        addr_b       = '0;
        issue_tag    = '0;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        unique case (state_reg)
            ctwb_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                ph_next  = '0;
                cnt_next = '0;
            end
            ctwb_pkg::ST_MAT: begin
                addr_a          = {base_a, cnt_reg[5:4], cnt_reg[1:0]};
                addr_b          = {base_b, cnt_reg[1:0], cnt_reg[3:2]};
                issue_tag.valid = 1'b1;
                issue_tag.first = (cnt_reg[1:0] == 2'd0);
                issue_tag.last  = (cnt_reg[1:0] == 2'd3);
                issue_tag.dest  = {base_d, cnt_reg[5:4], cnt_reg[3:2]};
                if (cnt_reg[5:0] == 6'd63) begin
                    cnt_next = '0;
                    ph_next  = ph_reg + 2'd1;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ctwb_pkg::ST_BND: begin
                addr_a           = {REG_C, cnt_reg[6:5], cnt_reg[1:0]};
                issue_tag.valid  = 1'b1;
                issue_tag.bounds = 1'b1;
                issue_tag.first  = (cnt_reg[1:0] == 2'd0);
                issue_tag.last   = (cnt_reg[1:0] == 2'd3);
                issue_tag.ax     = cnt_reg[6:5];
                issue_tag.corner = cnt_reg[4:2];
                cnt_next         = (cnt_reg == BND_LAST) ? 7'd0 : cnt_reg + 7'd1;
                drain_next       = '0;
            end
            ctwb_pkg::ST_DRAIN: begin
                drain_next = drain_reg + 4'd1;
                emit_next  = '0;
            end
            ctwb_pkg::ST_EMIT_RD: begin
                // composed store is row-major: row in emit[1:0], column in emit[3:2]
                addr_a = {REG_C, emit_reg[1:0], emit_reg[3:2]};
            end
            ctwb_pkg::ST_EMIT_OUT: begin
                m_valid_next = 1'b1;
                if (emit_reg[4]) begin
                    out_next.kind         = ctwb_pkg::KIND_BOUNDS;
                    out_next.out_row      = emit_reg[1:0];
                    out_next.out_col      = 2'd0;
                    out_next.first_value  = lo_res_reg[emit_reg[1:0]];
                    out_next.second_value = hi_res_reg[emit_reg[1:0]];
                    out_next.last         = (emit_reg[1:0] == AXIS_LAST);
                end else begin
                    out_next.kind         = ctwb_pkg::KIND_ENTRY;
                    out_next.out_row      = emit_reg[1:0];
                    out_next.out_col      = emit_reg[3:2];
                    out_next.first_value  = rd_a_reg;
                    out_next.second_value = '0;
                    out_next.last         = 1'b0;
                end
            end
            ctwb_pkg::ST_EMIT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    emit_next    = emit_reg + 5'd1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ctwb_pkg::ST_IDLE;
            ph_reg      <= '0;
            cnt_reg     <= '0;
            drain_reg   <= '0;
            emit_reg    <= '0;
            m_valid_reg <= 1'b0;
            tag1_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            cnt_reg     <= cnt_next;
            drain_reg   <= drain_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
            tag1_reg    <= issue_tag;
        end
    end

    // Hold the result word and the corner operand
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        bnd_reg <= bnd_op_next;
    end

    // Write port: accumulator results, otherwise loads
    assign load_fire = s_valid && s_ready;
    assign acc_we    = res_tag.valid && res_tag.last && !res_tag.bounds;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {REG_P, s_data.row, s_data.col};
        mem_wdata = sat_in(s_data.value_a);
        if (acc_we) begin
            mem_we    = 1'b1;
            mem_waddr = res_tag.dest;
            mem_wdata = acc_sum;
        end else if (load_fire && (s_data.cmd == ctwb_pkg::CMD_LOAD_FIXED)
                     && (s_data.matrix_sel != ctwb_pkg::SEL_NONE)) begin
            mem_we    = 1'b1;
            mem_waddr = {1'b0, s_data.matrix_sel, s_data.row, s_data.col};
        end else if (load_fire && (s_data.cmd == ctwb_pkg::CMD_LOAD_PLACE)) begin
            mem_we = 1'b1;
        end
    end

    // Operand store: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Local box bounds
    always_ff @(posedge aclk) begin
        if (load_fire && (s_data.cmd == ctwb_pkg::CMD_LOAD_BOUNDS)
            && (s_data.row != ctwb_pkg::AXIS_NONE)) begin
            lower_reg[s_data.row] <= sat_in(s_data.value_a);
            upper_reg[s_data.row] <= sat_in(s_data.value_b);
        end
    end

    assign mul_b = tag1_reg.bounds ? bnd_reg : rd_b_reg;

    ctwb_fx_mul #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fx_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (tag1_reg),
        .op_a     (rd_a_reg),
        .op_b     (mul_b),
        .out_tag  (res_tag),
        .out_value(res_value)
    );

    // Accumulate four terms, then track the corner extremes
    always_comb begin
        acc_sum = res_tag.first ? res_value : sat_add(acc_reg, res_value);
        lo_new  = ((res_tag.corner == 3'd0) || (acc_sum < lo_run_reg)) ? acc_sum
                                                                       : lo_run_reg;
        hi_new  = ((res_tag.corner == 3'd0) || (acc_sum > hi_run_reg)) ? acc_sum
                                                                       : hi_run_reg;
    end

    always_ff @(posedge aclk) begin
        if (res_tag.valid) begin
            acc_reg <= acc_sum;
        end
        if (res_tag.valid && res_tag.last && res_tag.bounds) begin
            lo_run_reg <= lo_new;
            hi_run_reg <= hi_new;
            if (res_tag.corner == CORNER_LAST) begin
                lo_res_reg[res_tag.ax] <= lo_new;
                hi_res_reg[res_tag.ax] <= hi_new;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_valid_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ctwb_pkg::ST_EMIT_WAIT))
        else $error("result valid outside the wait state");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!res_tag.valid && !tag1_reg.valid))
        else $error("multiplier busy while taking input words");

    a_acc_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_we |-> (state_reg != ctwb_pkg::ST_IDLE))
        else $error("accumulator write collides with a load");

    a_last_is_axis2: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |->
            ((m_data.kind == ctwb_pkg::KIND_BOUNDS) && (emit_reg == EMIT_LAST)))
        else $error("last flag on the wrong result");
`endif

endmodule

>>> rtl/ctwb_mul_cell.sv
// One cell of the multiplier chain: adds one 32x32 partial product.
module ctwb_mul_cell #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctwb_pkg::mul_lane_t lane_in,
    output ctwb_pkg::mul_lane_t lane_out
);

    localparam bit A_HI  = (IDX % 2) == 1;
    localparam bit B_HI  = (IDX / 2) == 1;
    localparam int SHIFT = ctwb_pkg::HALF_W * ((IDX % 2) + (IDX / 2));

    logic [ctwb_pkg::HALF_W-1:0] a_half;
    logic [ctwb_pkg::HALF_W-1:0] b_half;
    logic [ctwb_pkg::DATA_W-1:0] pp;
    ctwb_pkg::mul_lane_t         lane_next;
    ctwb_pkg::mul_lane_t         lane_reg;

    // Pick this cell's halves and fold the partial product in
    always_comb begin
        a_half = A_HI ? lane_in.a_mag[63:32] : lane_in.a_mag[31:0];
        b_half = B_HI ? lane_in.b_mag[63:32] : lane_in.b_mag[31:0];
        pp     = a_half * b_half;
        lane_next     = lane_in;
        lane_next.acc = lane_in.acc + (ctwb_pkg::PROD_W'(pp) << SHIFT);
    end

    // Hand on to the neighbour every cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
        end else begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/ctwb_fx_mul.sv
// Fixed-point multiplier: sign split, chain of partial-product cells, round and saturate.
module ctwb_fx_mul #(
    parameter int VALUE_WIDTH = ctwb_pkg::VALUE_WIDTH,
    parameter int FRAC_BITS   = ctwb_pkg::FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctwb_pkg::tag_t     in_tag,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output ctwb_pkg::tag_t     out_tag,
    output logic signed [63:0] out_value
);

    localparam int PW = ctwb_pkg::PROD_W;
    localparam int NC = ctwb_pkg::MUL_CELLS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam int CHK_SHIFT = FRAC_BITS + VALUE_WIDTH - 1;
    localparam logic signed [64:0] VMAX_X = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
    localparam logic signed [63:0] VMAX = VMAX_X[63:0];
    localparam logic signed [63:0] VMIN = ~VMAX_X[63:0];

    ctwb_pkg::mul_lane_t   prep_next;
    ctwb_pkg::mul_lane_t   lane0_reg;
    ctwb_pkg::mul_lane_t   lane [NC+1];
    logic signed [PW-1:0]  s_sum;
    logic signed [PW-1:0]  hi_part;
    logic                  fits;
    ctwb_pkg::tag_t        tag_reg;
    logic signed [63:0]    value_reg;
    logic signed [63:0]    value_next;

    // Split operands into sign and magnitude, clear the running sum
    always_comb begin
        prep_next.tag   = in_tag;
        prep_next.neg   = op_a[63] ^ op_b[63];
        prep_next.a_mag = op_a[63] ? 64'(-op_a) : 64'(op_a);
        prep_next.b_mag = op_b[63] ? 64'(-op_b) : 64'(op_b);
        prep_next.acc   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane0_reg <= '0;
        end else begin
            lane0_reg <= prep_next;
        end
    end

    assign lane[0] = lane0_reg;

    // Chain of cells, one partial product each
    for (genvar g = 0; g < NC; g++) begin : g_cell
        ctwb_mul_cell #(
            .IDX(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .lane_in (lane[g]),
            .lane_out(lane[g+1])
        );
    end

    // Restore sign, round half up, drop fraction and saturate
    always_comb begin
        s_sum = (lane[NC].acc ^ {PW{lane[NC].neg}}) + PW'(lane[NC].neg) + HALF;
        hi_part = s_sum >>> CHK_SHIFT;
        fits = (hi_part == '0) || (hi_part == '1);
        if (fits) begin
            value_next = s_sum[FRAC_BITS +: 64];
        end else begin
            value_next = s_sum[PW-1] ? VMIN : VMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= '0;
            value_reg <= '0;
        end else begin
            tag_reg   <= lane[NC].tag;
            value_reg <= value_next;
        end
    end

    assign out_tag   = tag_reg;
    assign out_value = value_reg;

endmodule
